### hw/rtl/assert_macros.svh
// Assertion macros for RTL that checks its own behavior; the filter top level uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define WMF_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wmf assertion failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define WMF_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wmf assertion failed");

`endif

### hw/rtl/wmf_pkg.sv
// Package with the sizes, codes and types of the window median filter.
`default_nettype none
package wmf_pkg;
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int MAX_RADIUS  = 2;
	localparam int WIN_SIDE    = 2 * MAX_RADIUS + 1;
	localparam int WIN_N       = WIN_SIDE * WIN_SIDE;
	localparam int CENTER_IDX  = MAX_RADIUS * WIN_SIDE + MAX_RADIUS;
	localparam int HIST_DEPTH  = 2 * (MAX_RADIUS * MAX_WIDTH + MAX_RADIUS) + 1;
	localparam int ADDR_W      = $clog2(HIST_DEPTH);
	localparam int PEND_MAX    = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1;
	localparam int PEND_W      = $clog2(PEND_MAX + 1);
	localparam int OFF_W       = $clog2(PEND_MAX + MAX_RADIUS + 2) + 1;
	localparam int CFG_W       = 11;
	localparam int RAD_W       = 2;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);
	localparam int RANK_W      = $clog2(WIN_N + 1);
	localparam int FILL_LAST   = 2 * MAX_RADIUS + 1;
	localparam int SOFF_W      = $clog2(2 * MAX_RADIUS + 3);

	localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [1:0] CFG_WINDOW_RADIUS = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t [WIN_N-1:0]     vals;
		logic [WIN_N-1:0]     mask;
		logic [RANK_W-1:0]    rank_k;
		logic                 interior;
		logic                 frame_end;
	} win_snap_t;
endpackage
`default_nettype wire

### hw/rtl/wmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### hw/rtl/wmf_median.sv
// Rank-based median selection over a captured window, centre pixel at borders, one register stage.
`default_nettype none
module wmf_median import wmf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      load,
	input  wire win_snap_t snap,
	output pix_t           median,
	output logic           frame_end
);
	logic [WIN_N-1:0] lt_c  [WIN_N];
	logic [WIN_N-1:0] lt_s2 [WIN_N];
	pix_t [WIN_N-1:0] vals_s2;
	logic [WIN_N-1:0] mask_s2;
	logic [RANK_W-1:0] k_s2;
	logic interior_s2;
	logic fe_s2;

	// An element ranks below another when it is smaller, or equal and earlier.
	always_comb begin
		for (int i = 0; i < WIN_N; i++) begin
			for (int j = 0; j < WIN_N; j++) begin
				lt_c[i][j] = snap.mask[j] && ((snap.vals[j] < snap.vals[i]) ||
					((snap.vals[j] == snap.vals[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < WIN_N; i++) begin
				lt_s2[i] <= lt_c[i];
			end
			vals_s2     <= snap.vals;
			mask_s2     <= snap.mask;
			k_s2        <= snap.rank_k;
			interior_s2 <= snap.interior;
			fe_s2       <= snap.frame_end;
		end
	end

	always_comb begin
		pix_t acc;
		acc = '0;
		for (int i = 0; i < WIN_N; i++) begin
			if (mask_s2[i] && (RANK_W'($countones(lt_s2[i])) == k_s2)) begin
				acc = acc | vals_s2[i];
			end
		end
		median = interior_s2 ? acc : vals_s2[CENTER_IDX];
	end

	assign frame_end = fe_s2;
endmodule
`default_nettype wire

### hw/rtl/window_median_filter_gray_unit.sv
// Top level of the streaming square-window median filter for gray frames.
// Input channel: in_valid/in_stall with cmd and pixel_in. cmd 0 carries a
// pixel in raster order, cmd 1 drains one pending output pixel.
// Output channel: out_valid/out_stall with pixel_out and frame_end, in raster
// order; frame_end marks the last pixel of a frame.
// The configuration port takes a write on every clock with cfg_we high; the user
// must use it only while the block is idle, as the block does not enforce this.
// Pixel history lives in five copies of a ring memory, one per window row, so
// that a full window column is fetched every cycle.
// Throughput is one transaction per cycle while in_stall is low. A result is
// registered in snap_s1, in the median stage and in pixel_out; the filter releases
// a pixel once radius rows plus radius pixels of history follow it.
// After reset and after every configuration write the window registers are
// reloaded from the history memory, with in_stall held high until the reload ends.
// When out_stall holds a result, the three pipeline stages fill up before
// in_stall is raised.
`default_nettype none
`include "assert_macros.svh"
module window_median_filter_gray_unit import wmf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              cmd,
	input  wire logic [7:0]        pixel_in,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        pixel_out,
	output logic                   frame_end,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);
	logic [CFG_W-1:0] cfg_w_q, cfg_h_q;
	logic [RAD_W-1:0] cfg_r_q;
	logic [CFG_W-1:0] w_eff, h_eff;
	logic [RAD_W-1:0] r_eff;
	logic [PEND_W-1:0] delay;

	logic [ADDR_W-1:0] pos_q, wr_q;
	logic [PEND_W-1:0] pend_q;
	logic [ROW_W-1:0] orow_q;
	logic [COL_W-1:0] ocol_q;
	logic busy_q;
	logic [SOFF_W-1:0] fcnt_q;

	pix_t win_q [WIN_SIDE][WIN_SIDE];
	pix_t win_f [WIN_SIDE][WIN_SIDE];
	logic hit [WIN_SIDE][WIN_SIDE];
	pix_t nxt_f [WIN_SIDE];
	logic nxt_hit [WIN_SIDE];
	logic byp_hit [WIN_SIDE];
	logic [WIN_SIDE-1:0] byp_q;
	pix_t byp_pix_q;
	pix_t ram_dout [WIN_SIDE];
	logic [ADDR_W-1:0] raddr [WIN_SIDE];
	logic [ADDR_W-1:0] rowoff [WIN_SIDE];
	logic signed [OFF_W-1:0] drw [WIN_SIDE];
	logic signed [OFF_W-1:0] pend_s, pend_e;

	logic in_acc, px_acc, emit;
	logic adv_out, adv2, adv1;
	logic s1_v_q, s2_v_q;
	win_snap_t snap_d, snap_s1;
	pix_t med;
	logic med_fe;
	logic out_v_q;
	pix_t pix_q;
	logic fe_q;

	logic [SOFF_W-1:0] soff;
	logic [ADDR_W+1:0] b0, b1, b2;
	logic [ADDR_W-1:0] base;
	logic interior, col_last, row_last;

	assign w_eff = (cfg_w_q == '0) ? CFG_W'(1) :
		((cfg_w_q > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_w_q);
	assign h_eff = (cfg_h_q == '0) ? CFG_W'(1) :
		((cfg_h_q > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : cfg_h_q);
	assign r_eff = (cfg_r_q > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_r_q;
	assign delay = PEND_W'(w_eff) * PEND_W'(r_eff) + PEND_W'(r_eff);

	// Row offsets, both as ring distances and as signed distances.
	for (genvar d = 0; d < WIN_SIDE; d++) begin : g_row
		localparam int DR = d - MAX_RADIUS;
		localparam int AD = (DR < 0) ? -DR : DR;
		logic [ADDR_W-1:0] prod;
		assign prod = ADDR_W'(AD) * ADDR_W'(w_eff);
		assign rowoff[d] = (DR < 0) ? ADDR_W'(HIST_DEPTH) - prod : prod;
		assign drw[d] = (DR < 0) ? -$signed(OFF_W'(prod)) : $signed(OFF_W'(prod));
	end

	// Handshake and pipeline advance.
	assign adv_out  = !out_v_q || !out_stall;
	assign adv2     = !s2_v_q || adv_out;
	assign adv1     = !s1_v_q || adv2;
	assign in_stall = busy_q || !adv1;
	assign in_acc   = in_valid && !in_stall;
	assign px_acc   = in_acc && (cmd == CMD_PIXEL);
	assign emit     = in_acc && ((cmd == CMD_PIXEL) ?
		(({1'b0, pend_q} + 1'b1) > {1'b0, delay}) : (pend_q != '0));

	assign pend_s = $signed(OFF_W'(pend_q));
	assign pend_e = pend_s - $signed(OFF_W'(emit));

	// A write at the ring head updates any window entry it lands on.
	for (genvar d = 0; d < WIN_SIDE; d++) begin : g_fwd
		localparam logic signed [OFF_W-1:0] NXT = OFF_W'(MAX_RADIUS + 1);
		for (genvar c = 0; c < WIN_SIDE; c++) begin : g_col
			localparam logic signed [OFF_W-1:0] DC = OFF_W'(c - MAX_RADIUS);
			assign hit[d][c]   = px_acc && (pend_s == drw[d] + DC);
			assign win_f[d][c] = hit[d][c] ? pixel_in : win_q[d][c];
		end
		assign nxt_hit[d] = px_acc && (pend_s == drw[d] + NXT);
		assign byp_hit[d] = px_acc && (pend_e == drw[d] + NXT);
		assign nxt_f[d]   = nxt_hit[d] ? pixel_in : (byp_q[d] ? byp_pix_q : ram_dout[d]);
	end

	// Read address of the column the window needs next.
	assign soff = busy_q ? fcnt_q :
		(emit ? SOFF_W'(2 * MAX_RADIUS + 2) : SOFF_W'(2 * MAX_RADIUS + 1));
	assign b0 = (ADDR_W+2)'(pos_q) + (ADDR_W+2)'(HIST_DEPTH - MAX_RADIUS) + (ADDR_W+2)'(soff);
	assign b1 = (b0 >= (ADDR_W+2)'(HIST_DEPTH)) ? b0 - (ADDR_W+2)'(HIST_DEPTH) : b0;
	assign b2 = (b1 >= (ADDR_W+2)'(HIST_DEPTH)) ? b1 - (ADDR_W+2)'(HIST_DEPTH) : b1;
	assign base = ADDR_W'(b2);

	for (genvar d = 0; d < WIN_SIDE; d++) begin : g_mem
		logic [ADDR_W:0] sum;
		assign sum = (ADDR_W+1)'(base) + (ADDR_W+1)'(rowoff[d]);
		assign raddr[d] = (sum >= (ADDR_W+1)'(HIST_DEPTH)) ?
			ADDR_W'(sum - (ADDR_W+1)'(HIST_DEPTH)) : ADDR_W'(sum);
		wmf_ram #(.WIDTH(8), .DEPTH(HIST_DEPTH)) u_hist (
			.clk   (clk),
			.we    (px_acc),
			.waddr (wr_q),
			.wdata (pixel_in),
			.raddr (raddr[d]),
			.rdata (ram_dout[d])
		);
	end

	assign interior = ({1'b0, orow_q} >= CFG_W'(r_eff)) &&
		(CFG_W'(orow_q) + CFG_W'(r_eff) < h_eff) &&
		({1'b0, ocol_q} >= CFG_W'(r_eff)) &&
		(CFG_W'(ocol_q) + CFG_W'(r_eff) < w_eff);
	assign col_last = (CFG_W'(ocol_q) + 1'b1) >= w_eff;
	assign row_last = (CFG_W'(orow_q) + 1'b1) >= h_eff;

	always_comb begin
		for (int d = 0; d < WIN_SIDE; d++) begin
			for (int c = 0; c < WIN_SIDE; c++) begin
				snap_d.vals[d*WIN_SIDE+c] = win_f[d][c];
				snap_d.mask[d*WIN_SIDE+c] =
					(RAD_W'((d < MAX_RADIUS) ? MAX_RADIUS - d : d - MAX_RADIUS) <= r_eff) &&
					(RAD_W'((c < MAX_RADIUS) ? MAX_RADIUS - c : c - MAX_RADIUS) <= r_eff);
			end
		end
		snap_d.rank_k    = RANK_W'(2) * RANK_W'(r_eff) * (RANK_W'(r_eff) + 1'b1);
		snap_d.interior  = interior;
		snap_d.frame_end = col_last && row_last;
	end

	// Configuration and refill sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= CFG_W'(640);
			cfg_h_q <= CFG_W'(480);
			cfg_r_q <= RAD_W'(1);
			busy_q  <= 1'b1;
			fcnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: begin
						cfg_w_q <= cfg_data;
					end
					CFG_IMAGE_HEIGHT: begin
						cfg_h_q <= cfg_data;
					end
					CFG_WINDOW_RADIUS: begin
						cfg_r_q <= cfg_data[RAD_W-1:0];
					end
					default: begin
					end
				endcase
				busy_q <= 1'b1;
				fcnt_q <= '0;
			end else if (busy_q) begin
				if (fcnt_q == SOFF_W'(FILL_LAST)) begin
					busy_q <= 1'b0;
				end
				fcnt_q <= fcnt_q + 1'b1;
			end
		end
	end

	// Ring pointers, pending count and output raster position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			wr_q   <= '0;
			pend_q <= '0;
			orow_q <= '0;
			ocol_q <= '0;
			byp_q  <= '0;
		end else begin
			for (int d = 0; d < WIN_SIDE; d++) begin
				byp_q[d] <= !busy_q && byp_hit[d];
			end
			if (px_acc) begin
				wr_q <= (wr_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			pend_q <= pend_q + PEND_W'(px_acc) - PEND_W'(emit);
			if (emit) begin
				pos_q <= (pos_q == ADDR_W'(HIST_DEPTH - 1)) ? '0 : pos_q + 1'b1;
				if (col_last) begin
					ocol_q <= '0;
					orow_q <= row_last ? '0 : orow_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_pix_q <= pixel_in;
		for (int d = 0; d < WIN_SIDE; d++) begin
			for (int c = 0; c < WIN_SIDE; c++) begin
				if (busy_q) begin
					if (fcnt_q != '0) begin
						win_q[d][c] <= (c == WIN_SIDE - 1) ? ram_dout[d] : win_q[d][(c+1) % WIN_SIDE];
					end
				end else if (emit) begin
					win_q[d][c] <= (c == WIN_SIDE - 1) ? nxt_f[d] : win_f[d][(c+1) % WIN_SIDE];
				end else begin
					win_q[d][c] <= win_f[d][c];
				end
			end
		end
		if (emit) begin
			snap_s1 <= snap_d;
		end
		if (adv_out && s2_v_q) begin
			pix_q <= med;
			fe_q  <= med_fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (emit) begin
				s1_v_q <= 1'b1;
			end else if (adv2) begin
				s1_v_q <= 1'b0;
			end
			if (adv2) begin
				s2_v_q <= s1_v_q;
			end
			if (adv_out) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	wmf_median u_median (
		.clk       (clk),
		.load      (s1_v_q && adv2),
		.snap      (snap_s1),
		.median    (med),
		.frame_end (med_fe)
	);

	assign out_valid = out_v_q;
	assign pixel_out = pix_q;
	assign frame_end = fe_q;

	`WMF_ASSERT_IMP(a_pend_bound, 1'b1, pend_q <= PEND_W'(PEND_MAX))
	`WMF_ASSERT_IMP(a_emit_source, emit, (pend_q != '0) || px_acc)
	`WMF_ASSERT_NXT(a_cfg_refill, cfg_we, !in_acc)
	`WMF_ASSERT_NXT(a_s1_hold, s1_v_q && !adv2, s1_v_q)
endmodule
`default_nettype wire

### verif/window_median_filter_gray_unit_tb.sv
// Testbench for the streaming square-window median filter, checked against its own predictor.
`default_nettype none
module window_median_filter_gray_unit_tb;
	import wmf_pkg::*;

	typedef struct {
		pix_t px;
		logic fe;
	} filt_pixel_t;

	class median_scoreboard;
		int w_reg, h_reg, r_reg;
		pix_t hist[];
		bit written[];
		int wr, pending, in_row, in_col, out_row, out_col;
		filt_pixel_t expected_q[$];
		int errors, n_pixels, n_drains, n_results, n_frames;

		function new();
			hist = new[HIST_DEPTH];
			written = new[HIST_DEPTH];
			foreach (hist[i]) begin
				hist[i] = 0;
				written[i] = 0;
			end
			w_reg = 640;
			h_reg = 480;
			r_reg = 1;
			wr = 0;
			pending = 0;
			in_row = 0;
			in_col = 0;
			out_row = 0;
			out_col = 0;
		endfunction

		function int eff_w();
			return (w_reg == 0) ? 1 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : w_reg;
		endfunction

		function int eff_h();
			return (h_reg == 0) ? 1 : (h_reg > MAX_HEIGHT) ? MAX_HEIGHT : h_reg;
		endfunction

		function int eff_r();
			return (r_reg > MAX_RADIUS) ? MAX_RADIUS : r_reg;
		endfunction

		function void set_reg(logic [1:0] idx, int val);
			if (idx == CFG_IMAGE_WIDTH) begin
				w_reg = val;
			end else if (idx == CFG_IMAGE_HEIGHT) begin
				h_reg = val;
			end else if (idx == CFG_WINDOW_RADIUS) begin
				r_reg = val;
			end
		endfunction

		function int ring_at(int base, int off);
			int idx;
			idx = (base + off) % HIST_DEPTH;
			if (idx < 0) begin
				idx += HIST_DEPTH;
			end
			return idx;
		endfunction

		function bit is_interior();
			int w, h, r;
			w = eff_w();
			h = eff_h();
			r = eff_r();
			return out_row >= r && out_row + r < h && out_col >= r && out_col + r < w;
		endfunction

		// A drain is safe when the window it would gather holds only written history.
		function bit drain_safe();
			int w, r, pos;
			w = eff_w();
			r = eff_r();
			pos = (wr + HIST_DEPTH - pending) % HIST_DEPTH;
			if (pending == 0 || !is_interior()) begin
				return 1;
			end
			for (int dr = -r; dr <= r; dr++) begin
				for (int dc = -r; dc <= r; dc++) begin
					if (!written[ring_at(pos, dr * w + dc)]) begin
						return 0;
					end
				end
			end
			return 1;
		endfunction

		function void release_pixel();
			int w, h, r, pos, n, j;
			pix_t win[25];
			pix_t v;
			filt_pixel_t res;
			w = eff_w();
			h = eff_h();
			r = eff_r();
			pos = (wr + HIST_DEPTH - pending) % HIST_DEPTH;
			res.fe = 0;
			if (is_interior()) begin
				n = 0;
				for (int dr = -r; dr <= r; dr++) begin
					for (int dc = -r; dc <= r; dc++) begin
						win[n] = hist[ring_at(pos, dr * w + dc)];
						n++;
					end
				end
				for (int i = 1; i < n; i++) begin
					v = win[i];
					j = i;
					while (j > 0 && win[j-1] > v) begin
						win[j] = win[j-1];
						j--;
					end
					win[j] = v;
				end
				res.px = win[(n - 1) / 2];
			end else begin
				res.px = hist[pos];
			end
			if (out_col + 1 >= w) begin
				out_col = 0;
				if (out_row + 1 >= h) begin
					out_row = 0;
					res.fe = 1;
				end else begin
					out_row++;
				end
			end else begin
				out_col++;
			end
			pending--;
			expected_q.push_back(res);
		endfunction

		function void note_input(logic c, pix_t p);
			int w, h, r;
			w = eff_w();
			h = eff_h();
			r = eff_r();
			if (c == CMD_PIXEL) begin
				n_pixels++;
				hist[wr] = p;
				written[wr] = 1;
				wr = (wr + 1) % HIST_DEPTH;
				if (in_col + 1 >= w) begin
					in_col = 0;
					in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
				end else begin
					in_col++;
				end
				pending++;
				if (pending > r * w + r) begin
					release_pixel();
				end
			end else begin
				n_drains++;
				if (pending > 0) begin
					release_pixel();
				end
			end
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(pix_t px, logic fe);
			filt_pixel_t e;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected transaction pixel_out=%0d frame_end=%0d", px, fe));
			end else begin
				e = expected_q.pop_front();
				if (fe) begin
					n_frames++;
				end
				if (px !== e.px) begin
					report($sformatf("result %0d pixel_out=%0d, want %0d", n_results, px, e.px));
				end
				if (fe !== e.fe) begin
					report($sformatf("result %0d frame_end=%0d, want %0d", n_results, fe, e.fe));
				end
			end
		endtask
	endclass

	localparam int NUM_PHASES = 18;
	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic cmd = CMD_PIXEL;
	logic [7:0] pixel_in = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [7:0] pixel_out;
	logic frame_end;
	logic cfg_we = 0;
	logic [1:0] cfg_index = CFG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = 0;

	median_scoreboard sb = new();
	int send_idle_pct = 38;
	int recv_stall_pct = 64;
	int quiet_cycles = 0;

	window_median_filter_gray_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.frame_end(frame_end),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		if (out_valid && !out_stall) begin
			sb.check_result(pixel_out, frame_end);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles > STALL_LIMIT) begin
			$display("timeout with %0d results outstanding", sb.expected_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(logic c, pix_t p);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		pixel_in <= p;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_input(c, p);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic drain_all();
		while (sb.pending > 0) begin
			send(CMD_DRAIN, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_reg(logic [1:0] idx, int val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic configure(int w, int h, int r);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		write_reg(CFG_WINDOW_RADIUS, r);
		@(posedge clk);
	endtask

	task automatic feed_frame();
		int total;
		total = sb.eff_w() * sb.eff_h();
		for (int i = 0; i < total; i++) begin
			if ($urandom_range(0, 99) < 4 && sb.pending > 0 && sb.drain_safe()) begin
				send(CMD_DRAIN, 8'($urandom_range(0, 255)));
			end
			send(CMD_PIXEL, 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		int w, h, r, frames;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		configure(5, 4, 1);
		for (int i = 0; i < 20; i++) begin
			send(CMD_PIXEL, (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'(i * 37));
		end
		drain_all();
		send(CMD_DRAIN, 8'hFF);
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p * 3 / NUM_PHASES == 1) begin
				send_idle_pct = 64;
				recv_stall_pct = 38;
			end else if (p * 3 / NUM_PHASES == 2) begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 9);
			r = $urandom_range(0, 3);
			frames = $urandom_range(1, 2);
			case (p)
				3: begin
					w = 0; h = 3; r = 0;
				end
				7: begin
					w = 3; h = 0; r = 3;
				end
				12: begin
					w = 7; h = 9; r = 2;
				end
				default: ;
			endcase
			configure(w, h, r);
			if ($urandom_range(0, 9) == 0) begin
				send(CMD_DRAIN, 8'($urandom_range(0, 255)));
			end
			for (int f = 0; f < frames; f++) begin
				feed_frame();
			end
			drain_all();
			wait_drained();
		end

		in_valid <= 0;
		$display("covered %0d pixel and %0d drain transactions over %0d settings",
			sb.n_pixels, sb.n_drains, NUM_PHASES + 1);
		$display("checked %0d results spanning %0d frames", sb.n_results, sb.n_frames);
		if (sb.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/wmf_pkg.sv
hw/rtl/wmf_ram.sv
hw/rtl/wmf_median.sv
hw/rtl/window_median_filter_gray_unit.sv
verif/window_median_filter_gray_unit_tb.sv
